[rtl/cnfg_pkg.sv]
// Shared types and constants for the cylinder Nusselt number pipeline.
// Holds field widths, band codes and the Q30 fit coefficients; no dependencies.
package cnfg_pkg;

  localparam int GR_FRAC_BITS_DEF = 26;
  localparam int NU_FRAC_BITS_DEF = 24;

  localparam int GR_W   = 53;
  localparam int NU_W   = 32;
  localparam int BAND_W = 3;

  // Fourth root carries 22 fraction bits; blend weights carry 16.
  localparam int XF      = 22;
  localparam int WGT_W   = 16;
  // Width of the root used by the polynomial fits and of the fit values.
  localparam int XC_W    = 27;
  localparam int VAL_W   = 40;
  localparam int KTOP_W  = 29;
  localparam int ROOT_IN = 88;

  typedef enum logic [BAND_W-1:0] {
    BAND_ZERO    = 3'd0,
    BAND_TOP     = 3'd1,
    BAND_TOP_MIX = 3'd2,
    BAND_CUBIC   = 3'd3,
    BAND_MID_MIX = 3'd4,
    BAND_QA      = 3'd5,
    BAND_LOW_MIX = 3'd6,
    BAND_QB      = 3'd7
  } band_t;

  localparam logic [KTOP_W-1:0] K_TOP =
    KTOP_W'(((64'd395 << 27) + 64'd125 / 64'd2) / 64'd125);

  localparam logic signed [VAL_W-1:0] K_CUB0 =
    VAL_W'(((64'd1036258122680 << 18) + 64'd244140625 / 64'd2) / 64'd244140625);
  localparam logic signed [VAL_W-1:0] K_CUB1 =
    VAL_W'(((64'd3740943660128 << 17) + 64'd1220703125 / 64'd2) / 64'd1220703125);
  localparam logic signed [VAL_W-1:0] K_CUB2 =
    VAL_W'(-(((64'd4319246132012 << 15) + 64'd30517578125 / 64'd2) / 64'd30517578125));
  localparam logic signed [VAL_W-1:0] K_CUB3 =
    VAL_W'(((64'd1247228303931 << 14) + 64'd152587890625 / 64'd2) / 64'd152587890625);

  localparam logic signed [VAL_W-1:0] K_QA0 =
    VAL_W'(((64'd3625104307573 << 17) + 64'd1220703125 / 64'd2) / 64'd1220703125);
  localparam logic signed [VAL_W-1:0] K_QA1 =
    VAL_W'(((64'd8127569162631 << 17) + 64'd1220703125 / 64'd2) / 64'd1220703125);
  localparam logic signed [VAL_W-1:0] K_QA2 =
    VAL_W'(-(((64'd7526734702040 << 16) + 64'd6103515625 / 64'd2) / 64'd6103515625));

  localparam logic signed [VAL_W-1:0] K_QB0 =
    VAL_W'(((64'd4290799517673 << 17) + 64'd1220703125 / 64'd2) / 64'd1220703125);
  localparam logic signed [VAL_W-1:0] K_QB1 =
    VAL_W'(((64'd5356760861151 << 17) + 64'd1220703125 / 64'd2) / 64'd1220703125);
  localparam logic signed [VAL_W-1:0] K_QB2 =
    VAL_W'(((64'd1352439621176 << 17) + 64'd1220703125 / 64'd2) / 64'd1220703125);

endpackage

[rtl/cylinder_nusselt_from_grashof.sv]
// Top level of the cylinder Nusselt number pipeline.
// Depends on cnfg_pkg, cnfg_div, cnfg_isqrt and cnfg_fit.

// The block takes one item in every clock cycle and never reports busy: an item
// is accepted whenever start is high. Each item passes the front register, the
// divider, the two square-root pipelines, whose root widths are R1 and R2 (58
// and 29 bits at the default 26 fraction bits), and the fit stages in turn. Most
// of the latency lies in the two bit-per-stage square roots that form the fourth
// root of the Grashof number. A result is shown for exactly one cycle with done
// high and must be taken then; the receiver cannot hold results off, and results
// leave in the order the items entered.
module cylinder_nusselt_from_grashof #(
  parameter int GR_FRAC_BITS = cnfg_pkg::GR_FRAC_BITS_DEF,
  parameter int NU_FRAC_BITS = cnfg_pkg::NU_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cnfg_pkg::GR_W-1:0]     grashof,
  output logic                          busy,
  output logic                          done,
  output logic [cnfg_pkg::NU_W-1:0]     nusselt,
  output logic [cnfg_pkg::BAND_W-1:0]   band
);

  localparam int GW    = cnfg_pkg::GR_W;
  localparam int BW    = cnfg_pkg::BAND_W;
  localparam int QW    = cnfg_pkg::WGT_W;
  localparam int SHIFT = cnfg_pkg::ROOT_IN - GR_FRAC_BITS;
  localparam int OPW   = GW + SHIFT;
  localparam int W1    = OPW + (OPW % 2);
  localparam int R1    = W1 / 2;
  localparam int W2    = R1 + (R1 % 2);
  localparam int R2    = W2 / 2;

  // Band edges in raw input codes, rounded up so that the compare is exact.
  localparam logic [63:0] THR_TOP_HI =
    ((64'd1005000000 << GR_FRAC_BITS) + 64'd9999) / 64'd10000;
  localparam logic [63:0] THR_TOP_LO =
    ((64'd995000000 << GR_FRAC_BITS) + 64'd9999) / 64'd10000;
  localparam logic [63:0] THR_MID_HI =
    ((64'd1005000 << GR_FRAC_BITS) + 64'd9999) / 64'd10000;
  localparam logic [63:0] THR_MID_LO =
    ((64'd995000 << GR_FRAC_BITS) + 64'd9999) / 64'd10000;
  localparam logic [63:0] THR_LOW_HI =
    ((64'd1005 << GR_FRAC_BITS) + 64'd9999) / 64'd10000;
  localparam logic [63:0] THR_LOW_LO =
    ((64'd995 << GR_FRAC_BITS) + 64'd9999) / 64'd10000;

  localparam logic [GW-1:0] TOP_HI   = GW'(THR_TOP_HI);
  localparam logic [GW-1:0] TOP_LO   = GW'(THR_TOP_LO);
  localparam logic [GW-1:0] MID_HI   = GW'(THR_MID_HI);
  localparam logic [GW-1:0] MID_LO   = GW'(THR_MID_LO);
  localparam logic [GW-1:0] LOW_HI   = GW'(THR_LOW_HI);
  localparam logic [GW-1:0] LOW_LO   = GW'(THR_LOW_LO);
  localparam logic [GW-1:0] SPAN_TOP = GW'(THR_TOP_HI - THR_TOP_LO);
  localparam logic [GW-1:0] SPAN_MID = GW'(THR_MID_HI - THR_MID_LO);
  localparam logic [GW-1:0] SPAN_LOW = GW'(THR_LOW_HI - THR_LOW_LO);

  // The block never stalls its sender.
  assign busy = 1'b0;

  // Front stage: sort the item into its band and form the window offset.
  cnfg_pkg::band_t band_next, band0;
  logic [GW-1:0]   lo_next, span_next, d_next;
  logic [GW-1:0]   g0, d0, span0;
  logic            v0;
  logic            mix;

  always_comb begin
    lo_next   = '0;
    span_next = GW'(1);
    mix       = 1'b0;
    if (grashof == '0) begin
      band_next = cnfg_pkg::BAND_ZERO;
    end else if (grashof >= TOP_HI) begin
      band_next = cnfg_pkg::BAND_TOP;
    end else if (grashof >= TOP_LO) begin
      band_next = cnfg_pkg::BAND_TOP_MIX;
      lo_next   = TOP_LO;
      span_next = SPAN_TOP;
      mix       = 1'b1;
    end else if (grashof >= MID_HI) begin
      band_next = cnfg_pkg::BAND_CUBIC;
    end else if (grashof >= MID_LO) begin
      band_next = cnfg_pkg::BAND_MID_MIX;
      lo_next   = MID_LO;
      span_next = SPAN_MID;
      mix       = 1'b1;
    end else if (grashof >= LOW_HI) begin
      band_next = cnfg_pkg::BAND_QA;
    end else if (grashof >= LOW_LO) begin
      band_next = cnfg_pkg::BAND_LOW_MIX;
      lo_next   = LOW_LO;
      span_next = SPAN_LOW;
      mix       = 1'b1;
    end else begin
      band_next = cnfg_pkg::BAND_QB;
    end
    d_next = mix ? (grashof - lo_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    g0    <= grashof;
    band0 <= band_next;
    d0    <= d_next;
    span0 <= span_next;
  end

  // Blend weight: offset into the window over the window width, 16 bits.
  logic            v_div;
  logic [QW-1:0]   w_div;
  logic [GW+BW-1:0] side_div;

  cnfg_div #(
    .DW (GW),
    .SW (GW + BW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .num       (d0),
    .den       (span0),
    .in_side   ({g0, band0}),
    .out_valid (v_div),
    .quo       (w_div),
    .out_side  (side_div)
  );

  // Fourth root as the square root of a square root of the scaled input.
  logic [W1-1:0]    op1;
  logic             v_sq1;
  logic [R1-1:0]    y;
  logic [BW+QW-1:0] side_sq1;

  assign op1 = W1'({side_div[GW+BW-1:BW], {SHIFT{1'b0}}});

  cnfg_isqrt #(
    .W  (W1),
    .SW (BW + QW)
  ) u_sqrt_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_div),
    .op        (op1),
    .in_side   ({side_div[BW-1:0], w_div}),
    .out_valid (v_sq1),
    .root      (y),
    .out_side  (side_sq1)
  );

  logic             v_sq2;
  logic [R2-1:0]    x;
  logic [BW+QW-1:0] side_sq2;

  cnfg_isqrt #(
    .W  (W2),
    .SW (BW + QW)
  ) u_sqrt_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_sq1),
    .op        (W2'(y)),
    .in_side   (side_sq1),
    .out_valid (v_sq2),
    .root      (x),
    .out_side  (side_sq2)
  );

  // Fits, blend and clamping, ending in the output register.
  cnfg_fit #(
    .XW           (R2),
    .NU_FRAC_BITS (NU_FRAC_BITS)
  ) u_fit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_sq2),
    .x        (x),
    .in_band  (cnfg_pkg::band_t'(side_sq2[BW+QW-1:QW])),
    .wgt      (side_sq2[QW-1:0]),
    .done     (done),
    .nusselt  (nusselt),
    .band     (band)
  );

endmodule

[rtl/cnfg_div.sv]
// Pipelined restoring divider producing the blend weight, one quotient bit a stage.
// Uses cnfg_pkg for the weight width; the divisor travels with each item.
module cnfg_div #(
  parameter int DW = 53,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [cnfg_pkg::WGT_W-1:0] quo,
  output logic [SW-1:0] out_side
);

  localparam int QW = cnfg_pkg::WGT_W;

  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [DW-1:0] dsr  [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic [SW-1:0] side [0:QW];

  assign vld[0]  = in_valid;
  assign rem[0]  = num;
  assign dsr[0]  = den;
  assign q[0]    = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    // The remainder stays below the divisor, so the doubled value fits DW+1 bits.
    always_comb begin
      t    = {rem[i], 1'b0};
      diff = t - {1'b0, dsr[i]};
      ge   = (t >= {1'b0, dsr[i]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
      dsr[i+1]  <= dsr[i];
      q[i+1]    <= {q[i][QW-2:0], ge};
      side[i+1] <= side[i];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign out_side  = side[QW];

endmodule

[rtl/cnfg_isqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit a stage.
// Generic in operand width; carries a sideband alongside each item.
module cnfg_isqrt #(
  parameter int W  = 116,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [W-1:0]    op,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [W/2-1:0]  root,
  output logic [SW-1:0]   out_side
);

  localparam int R = W / 2;

  logic          vld  [0:R];
  logic [R+1:0]  rem  [0:R];
  logic [R-1:0]  rt   [0:R];
  logic [W-1:0]  opr  [0:R];
  logic [SW-1:0] side [0:R];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign opr[0]  = op;
  assign side[0] = in_side;

  for (genvar i = 0; i < R; i++) begin : g_stage
    logic [R+1:0] rem_sh;
    logic [R+1:0] trial;
    logic         ge;

    always_comb begin
      rem_sh = {rem[i][R-1:0], opr[i][W-1:W-2]};
      trial  = {rt[i], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
      rt[i+1]   <= {rt[i][R-2:0], ge};
      opr[i+1]  <= {opr[i][W-3:0], 2'b00};
      side[i+1] <= side[i];
    end
  end

  assign out_valid = vld[R];
  assign root      = rt[R];
  assign out_side  = side[R];

endmodule

[rtl/cnfg_fit.sv]
// Fit evaluation: Horner steps of the three polynomials, top fit, blend, saturation.
// Uses cnfg_pkg for coefficients, band codes and widths.
module cnfg_fit #(
  parameter int XW           = 29,
  parameter int NU_FRAC_BITS = cnfg_pkg::NU_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [XW-1:0]                x,
  input  cnfg_pkg::band_t              in_band,
  input  logic [cnfg_pkg::WGT_W-1:0]   wgt,
  output logic                         done,
  output logic [cnfg_pkg::NU_W-1:0]    nusselt,
  output logic [cnfg_pkg::BAND_W-1:0]  band
);

  localparam int VW  = cnfg_pkg::VAL_W;
  localparam int CW  = cnfg_pkg::XC_W;
  localparam int PW  = VW + CW + 1;
  localparam int TW  = cnfg_pkg::KTOP_W + XW;
  localparam int FW  = cnfg_pkg::WGT_W + 1;
  localparam int MW  = VW + FW + 1;
  localparam int NW  = MW + 1 - cnfg_pkg::WGT_W;
  localparam int SH  = 30 - NU_FRAC_BITS;
  localparam int OW  = cnfg_pkg::NU_W;
  localparam logic [FW-1:0] ONE = FW'(1) << cnfg_pkg::WGT_W;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  cnfg_pkg::band_t b1, b2, b3, b4, b5, b6, b7, b8, b9;
  logic [cnfg_pkg::WGT_W-1:0] w1, w2, w3, w4, w5, w6;
  logic [CW-1:0] xc1, xc2, xc3, xc4;

  logic signed [PW-1:0] pc1, pa1, pb1, pc3, pa3, pb3, pc5;
  logic [TW-1:0]        pt1;
  logic signed [VW-1:0] ac2, aa2, ab2, top2, top3, top4, top5, top6;
  logic signed [VW-1:0] ac4, qa4, qb4, qa5, qb5, qa6, qb6, cub6;
  logic signed [VW-1:0] up7, dn7, up_sel, dn_sel;
  logic [FW-1:0]        wf7, wf_sel;
  logic signed [MW-1:0] mu8, md8;
  logic signed [NW-1:0] nu9, shifted;
  logic [NW-1:0]        shifted_u;

  logic signed [CW:0] xs, xs3, xs5;
  assign xs  = $signed({1'b0, x[CW-1:0]});
  assign xs3 = $signed({1'b0, xc2});
  assign xs5 = $signed({1'b0, xc4});

  // Stage 1: first multiplication of each fit.
  always_ff @(posedge clk) begin
    pc1 <= cnfg_pkg::K_CUB3 * xs;
    pa1 <= cnfg_pkg::K_QA2 * xs;
    pb1 <= cnfg_pkg::K_QB2 * xs;
    pt1 <= TW'(cnfg_pkg::K_TOP) * TW'(x);
    xc1 <= x[CW-1:0];
    b1  <= in_band;
    w1  <= wgt;
  end

  // Stage 2: first Horner add and the top fit.
  always_ff @(posedge clk) begin
    ac2  <= cnfg_pkg::K_CUB2 + VW'(pc1 >>> cnfg_pkg::XF);
    aa2  <= cnfg_pkg::K_QA1 + VW'(pa1 >>> cnfg_pkg::XF);
    ab2  <= cnfg_pkg::K_QB1 + VW'(pb1 >>> cnfg_pkg::XF);
    top2 <= $signed(VW'(pt1 >> cnfg_pkg::XF));
    xc2  <= xc1;
    b2   <= b1;
    w2   <= w1;
  end

  // Stage 3 and 4: second Horner step.
  always_ff @(posedge clk) begin
    pc3  <= ac2 * xs3;
    pa3  <= aa2 * xs3;
    pb3  <= ab2 * xs3;
    top3 <= top2;
    xc3  <= xc2;
    b3   <= b2;
    w3   <= w2;
  end

  always_ff @(posedge clk) begin
    ac4  <= cnfg_pkg::K_CUB1 + VW'(pc3 >>> cnfg_pkg::XF);
    qa4  <= cnfg_pkg::K_QA0 + VW'(pa3 >>> cnfg_pkg::XF);
    qb4  <= cnfg_pkg::K_QB0 + VW'(pb3 >>> cnfg_pkg::XF);
    top4 <= top3;
    xc4  <= xc3;
    b4   <= b3;
    w4   <= w3;
  end

  // Stage 5 and 6: last Horner step of the cubic.
  always_ff @(posedge clk) begin
    pc5  <= ac4 * xs5;
    qa5  <= qa4;
    qb5  <= qb4;
    top5 <= top4;
    b5   <= b4;
    w5   <= w4;
  end

  always_ff @(posedge clk) begin
    cub6 <= cnfg_pkg::K_CUB0 + VW'(pc5 >>> cnfg_pkg::XF);
    qa6  <= qa5;
    qb6  <= qb5;
    top6 <= top5;
    b6   <= b5;
    w6   <= w5;
  end

  // Stage 7: pick the fits; a plain band uses full weight on the upper fit.
  always_comb begin
    up_sel = '0;
    dn_sel = '0;
    wf_sel = ONE;
    case (b6)
      cnfg_pkg::BAND_TOP: begin
        up_sel = top6;
      end
      cnfg_pkg::BAND_TOP_MIX: begin
        up_sel = top6;
        dn_sel = cub6;
        wf_sel = {1'b0, w6};
      end
      cnfg_pkg::BAND_CUBIC: begin
        up_sel = cub6;
      end
      cnfg_pkg::BAND_MID_MIX: begin
        up_sel = cub6;
        dn_sel = qa6;
        wf_sel = {1'b0, w6};
      end
      cnfg_pkg::BAND_QA: begin
        up_sel = qa6;
      end
      cnfg_pkg::BAND_LOW_MIX: begin
        up_sel = qa6;
        dn_sel = qb6;
        wf_sel = {1'b0, w6};
      end
      cnfg_pkg::BAND_QB: begin
        up_sel = qb6;
      end
      default: begin
        up_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    up7 <= up_sel;
    dn7 <= dn_sel;
    wf7 <= wf_sel;
    b7  <= b6;
  end

  // Stage 8: weighted products; stage 9: sum and floor by the weight scale.
  always_ff @(posedge clk) begin
    mu8 <= up7 * $signed({1'b0, wf7});
    md8 <= dn7 * $signed({1'b0, ONE - wf7});
    b8  <= b7;
  end

  always_ff @(posedge clk) begin
    nu9 <= NW'(($signed({mu8[MW-1], mu8}) + $signed({md8[MW-1], md8}))
               >>> cnfg_pkg::WGT_W);
    b9  <= b8;
  end

  assign shifted   = nu9 >>> SH;
  assign shifted_u = shifted;

  // Stage 10: output register with clamping at both ends.
  always_ff @(posedge clk) begin
    if (nu9 < 0) begin
      nusselt <= '0;
    end else if (|shifted_u[NW-1:OW]) begin
      nusselt <= '1;
    end else begin
      nusselt <= shifted_u[OW-1:0];
    end
    band <= b9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      v9   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      v8   <= v7;
      v9   <= v8;
      done <= v9;
    end
  end

endmodule

[tb/tb_cylinder_nusselt_from_grashof.sv]
// Self-checking testbench for the cylinder Nusselt number pipeline.
// Depends on cnfg_pkg and cylinder_nusselt_from_grashof; holds its own predictor.
module tb_cylinder_nusselt_from_grashof;
  timeunit 1ns;
  timeprecision 1ps;
  import cnfg_pkg::*;

  // Cycles without any accepted item or result before the run is declared hung.
  // The sender never gaps for long.
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 1250;
  localparam int TAIL_WAIT  = 200;

  logic              clk;
  logic              rst;
  logic              start;
  logic [GR_W-1:0]   grashof;
  logic              busy;
  logic              done;
  logic [NU_W-1:0]   nusselt;
  logic [BAND_W-1:0] band;

  cylinder_nusselt_from_grashof dut (
    .clk(clk), .rst(rst), .start(start), .grashof(grashof),
    .busy(busy), .done(done), .nusselt(nusselt), .band(band)
  );

  // Raw threshold of a band edge n * 1e-4, rounded up so that "g >= edge" is exact.
  function automatic longint unsigned edge_raw(longint unsigned n);
    return ((n << 26) + 64'd9999) / 64'd10000;
  endfunction

  // Q30 coefficient m * 2^sh / d, rounded to nearest.
  function automatic longint q30(longint unsigned m, int sh, longint unsigned d);
    return longint'(((m << sh) + d / 2) / d);
  endfunction

  typedef struct {
    logic [NU_W-1:0] nu;
    band_t           bnd;
  } nu_result_t;

  // Scoreboard: predicts the Nusselt number of every accepted item and checks
  // the results against those predictions in arrival order.
  class nusselt_scoreboard;
    nu_result_t pending_nu[$];
    int errors;
    longint k_top;
    longint k_cub[4];
    longint k_qa[3];
    longint k_qb[3];

    function new();
      errors = 0;
      k_top    = q30(395, 27, 125);
      k_cub[0] = q30(64'd1036258122680, 18, 64'd244140625);
      k_cub[1] = q30(64'd3740943660128, 17, 64'd1220703125);
      k_cub[2] = -q30(64'd4319246132012, 15, 64'd30517578125);
      k_cub[3] = q30(64'd1247228303931, 14, 64'd152587890625);
      k_qa[0]  = q30(64'd3625104307573, 17, 64'd1220703125);
      k_qa[1]  = q30(64'd8127569162631, 17, 64'd1220703125);
      k_qa[2]  = -q30(64'd7526734702040, 16, 64'd6103515625);
      k_qb[0]  = q30(64'd4290799517673, 17, 64'd1220703125);
      k_qb[1]  = q30(64'd5356760861151, 17, 64'd1220703125);
      k_qb[2]  = q30(64'd1352439621176, 17, 64'd1220703125);
    endfunction

    function automatic longint unsigned int_sqrt(logic [127:0] n);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = 62; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= n) r = c;
      end
      return r[63:0];
    endfunction

    // Horner evaluation in Q30 with the root in Q22; shifts round down.
    function automatic longint horner(longint c[], longint x);
      longint acc;
      acc = c[c.size()-1];
      for (int i = c.size() - 2; i >= 0; i--) acc = c[i] + ((acc * x) >>> XF);
      return acc;
    endfunction

    function automatic longint mix(longint unsigned g, longint unsigned lo,
                                   longint unsigned hi, longint up, longint dn);
      longint w;
      w = 0;
      if (hi != lo) w = longint'(((g - lo) << 16) / (hi - lo));
      return (w * up + (65536 - w) * dn) >>> 16;
    endfunction

    function automatic nu_result_t predict(logic [GR_W-1:0] g_in);
      nu_result_t res;
      longint unsigned g, y;
      longint x, nu, top, cub, qa, qb;
      longint c3[], c2a[], c2b[];
      g = g_in;
      c3 = k_cub; c2a = k_qa; c2b = k_qb;
      if (g == 0) begin
        res.nu = '0;
        res.bnd = BAND_ZERO;
        return res;
      end
      // Fourth root in Q22: two integer square roots of g * 2^(88-26).
      y = int_sqrt({75'd0, g_in} << (ROOT_IN - GR_FRAC_BITS_DEF));
      x = longint'(int_sqrt({64'd0, y}));
      top = longint'((unsigned'(k_top) * unsigned'(x)) >> XF);
      if (g >= edge_raw(1005000000)) begin
        res.bnd = BAND_TOP; nu = top;
      end else if (g >= edge_raw(995000000)) begin
        res.bnd = BAND_TOP_MIX;
        nu = mix(g, edge_raw(995000000), edge_raw(1005000000), top, horner(c3, x));
      end else if (g >= edge_raw(1005000)) begin
        res.bnd = BAND_CUBIC; nu = horner(c3, x);
      end else if (g >= edge_raw(995000)) begin
        res.bnd = BAND_MID_MIX;
        nu = mix(g, edge_raw(995000), edge_raw(1005000), horner(c3, x), horner(c2a, x));
      end else if (g >= edge_raw(1005)) begin
        res.bnd = BAND_QA; nu = horner(c2a, x);
      end else if (g >= edge_raw(995)) begin
        res.bnd = BAND_LOW_MIX;
        nu = mix(g, edge_raw(995), edge_raw(1005), horner(c2a, x), horner(c2b, x));
      end else begin
        res.bnd = BAND_QB; nu = horner(c2b, x);
      end
      // Floor from Q30 to Q24, then clamp to the unsigned 32-bit range.
      if (nu < 0) res.nu = '0;
      else if ((nu >>> (30 - NU_FRAC_BITS_DEF)) > 64'hFFFF_FFFF) res.nu = '1;
      else res.nu = NU_W'(nu >>> (30 - NU_FRAC_BITS_DEF));
      return res;
    endfunction

    function void note_item(logic [GR_W-1:0] g);
      pending_nu.push_back(predict(g));
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [NU_W-1:0] nu, logic [BAND_W-1:0] bnd);
      nu_result_t want;
      if (pending_nu.size() == 0) begin
        report($sformatf("unexpected result nusselt=%h band=%0d", nu, bnd));
        return;
      end
      want = pending_nu.pop_front();
      if (nu !== want.nu)
        report($sformatf("nusselt %h, predicted %h", nu, want.nu));
      if (bnd !== want.bnd)
        report($sformatf("band %0d, predicted %0d", bnd, want.bnd));
    endtask
  endclass

  nusselt_scoreboard sb;
  int idle_pct;
  int idle_count;

  always #5 clk = ~clk;

  // Accepted items and results are both taken at the rising edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_item(grashof);
    if (!rst && done) sb.check_result(nusselt, band);
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Offers one item from the falling edge and holds it until it is taken.
  // The sender may then idle for as long as random draws stay below the current phase's idle percentage.
  task send_item(logic [GR_W-1:0] g);
    @(negedge clk);
    start <= 1'b1;
    grashof <= g;
    do @(posedge clk); while (busy);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      grashof <= GR_W'({$urandom, $urandom});
      @(posedge clk);
    end
  endtask

  // Random Grashof value: mostly spread over every magnitude, with a good share
  // landing in or right at the edges of the blend windows.
  function automatic logic [GR_W-1:0] random_grashof();
    longint unsigned lo, hi, v;
    logic [127:0] span;
    int w;
    w = $urandom_range(0, 2);
    case (w)
      0: begin lo = edge_raw(995); hi = edge_raw(1005); end
      1: begin lo = edge_raw(995000); hi = edge_raw(1005000); end
      default: begin lo = edge_raw(995000000); hi = edge_raw(1005000000); end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        v = {$urandom, $urandom};
        v = v >> (64 - $urandom_range(1, 53));
      end
      5, 6: begin
        span = 128'(hi - lo) * $urandom_range(0, 65535);
        v = lo + longint'(span >> 16);
      end
      7, 8: begin
        v = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 64) - 32;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v[GR_W-1:0];
  endfunction

  initial begin
    longint unsigned edges[6];
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    grashof = '0;
    idle_pct = 0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items: zero, the smallest and largest inputs, unity, and each
    // band edge from just below, exactly on it, and midway through each window.
    edges = '{edge_raw(995), edge_raw(1005), edge_raw(995000), edge_raw(1005000),
              edge_raw(995000000), edge_raw(1005000000)};
    send_item('0);
    send_item(53'd1);
    send_item(53'd2);
    send_item('1);
    send_item(53'd1 << 52);
    send_item(53'd1 << 26);
    foreach (edges[i]) begin
      send_item(GR_W'(edges[i] - 1));
      send_item(GR_W'(edges[i]));
    end
    for (int i = 0; i < 6; i += 2) send_item(GR_W'((edges[i] + edges[i+1]) / 2));

    // Hold the sender until the pipeline has drained completely.
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_nu.size() != 0) @(posedge clk);

    // Random phases: after each item the sender keeps idling with a chance of 30 in a
    // hundred, then 50, and finally not at all; the pipeline drains once halfway through.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_pct = (n < RAND_ITEMS / 3) ? 30 : (n < 2 * RAND_ITEMS / 3) ? 50 : 0;
      if (n == RAND_ITEMS / 2) begin
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_nu.size() != 0) @(posedge clk);
      end
      send_item(random_grashof());
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.pending_nu.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cnfg_pkg.sv
rtl/cnfg_div.sv
rtl/cnfg_isqrt.sv
rtl/cnfg_fit.sv
rtl/cylinder_nusselt_from_grashof.sv
tb/tb_cylinder_nusselt_from_grashof.sv
